>>> hw/rtl/bpru_pkg.sv
package bpru_pkg;

  // configuration register indexes
  localparam logic [1:0] CfgPixelFormat = 2'd0;
  localparam logic [1:0] CfgImageWidth  = 2'd1;
  localparam logic [1:0] CfgImageHeight = 2'd2;
  localparam logic [1:0] CfgBottomUp    = 2'd3;

  // pixel format codes
  localparam logic [1:0] FmtRgb555 = 2'd0;
  localparam logic [1:0] FmtBgr24  = 2'd1;
  localparam logic [1:0] FmtBgra32 = 2'd2;

  // bytes per pixel
  localparam logic [2:0] BppRgb555 = 3'd2;
  localparam logic [2:0] BppBgr24  = 3'd3;
  localparam logic [2:0] BppBgra32 = 3'd4;

  // 5:5:5 field masks
  localparam logic [15:0] MaskBlue555  = 16'h001F;
  localparam logic [15:0] MaskGreen555 = 16'h03E0;
  localparam logic [15:0] MaskRed555   = 16'h7C00;

  localparam int unsigned DimW   = 13;
  localparam int unsigned CoordW = 12;

endpackage

>>> hw/rtl/bmp_pixel_row_unpacker.sv
// bmp_pixel_row_unpacker
// Unpacks the pixel array of an uncompressed bitmap that arrives one byte
// per transaction on the input channel (in_valid_i / in_ready_o, data_byte_i).
// Every 2, 3 or 4 bytes (16-bit 5:5:5, 24-bit BGR, 32-bit BGRA) one pixel
// transaction leaves on the output channel (out_valid_o / out_ready_i) with
// its color components, column, row and a frame_last flag. Row padding to a
// 4-byte boundary is dropped without a pixel.
// The configuration channel (cfg_valid_i, cfg_index_i, cfg_data_i) is always
// ready; the user must write it only while the block is idle, which the block
// itself does not enforce.
// Each accepted byte is first held in the input register; a pixel is loaded
// into the output register as its last byte leaves the input register.
// Throughput: one byte per cycle; the input register and the output register
// each hold one transaction, and the input stage advances whenever the output
// register is empty or being emptied in the same cycle.
// When the receiver stalls, the output register holds its pixel and one more
// byte waits in the input register before in_ready_o drops.
// Reset clears all counters, empties both registers and loads the register
// defaults: 24-bit format, 1x1 image, bottom-up rows.
module bmp_pixel_row_unpacker #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  // pixel output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic [11:0] column_o,
  output logic [11:0] row_o,
  output logic        frame_last_o
);
  import bpru_pkg::*;

  localparam logic [31:0] MaxW = 32'(MAX_WIDTH);
  localparam logic [31:0] MaxH = 32'(MAX_HEIGHT);

  // configuration registers
  logic [1:0]      pixel_format_q;
  logic [DimW-1:0] image_width_q;
  logic [DimW-1:0] image_height_q;
  logic            bottom_up_q;

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;

  // unpacker state
  logic [1:0]        byte_phase_q, byte_phase_d;
  logic [23:0]       pixel_bytes_q, pixel_bytes_d;
  logic [CoordW-1:0] col_count_q, col_count_d;
  logic [DimW-1:0]   rows_done_q, rows_done_d;
  logic [1:0]        pad_left_q, pad_left_d;

  // output register
  logic              out_valid_q;
  logic [7:0]        red_q, green_q, blue_q, alpha_q;
  logic [CoordW-1:0] column_q, row_q;
  logic              frame_last_q;

  logic              out_free, s1_fire, emit;
  logic [2:0]        bpp;
  logic [DimW-1:0]   w, h, rows_eff, row_full;
  logic [DimW:0]     col_next, rows_next;
  logic              last_col, last_row;
  logic [15:0]       v555;
  logic [7:0]        red_d, green_d, blue_d, alpha_d;
  logic [1:0]        pad_prod;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || out_free;
  assign s1_fire     = s1_valid_q && out_free;

  // config decode and dimension clamping
  always_comb begin
    case (pixel_format_q)
      FmtRgb555: bpp = BppRgb555;
      FmtBgra32: bpp = BppBgra32;
      default:   bpp = BppBgr24;
    endcase
    if (image_width_q == '0) begin
      w = DimW'(1);
    end else if (32'(image_width_q) > MaxW) begin
      w = MaxW[DimW-1:0];
    end else begin
      w = image_width_q;
    end
    if (image_height_q == '0) begin
      h = DimW'(1);
    end else if (32'(image_height_q) > MaxH) begin
      h = MaxH[DimW-1:0];
    end else begin
      h = image_height_q;
    end
  end

  // pixel assembly, coordinates and state update
  always_comb begin
    byte_phase_d  = byte_phase_q;
    pixel_bytes_d = pixel_bytes_q;
    col_count_d   = col_count_q;
    rows_done_d   = rows_done_q;
    pad_left_d    = pad_left_q;
    emit          = 1'b0;

    v555     = {s1_byte_q, pixel_bytes_q[7:0]};
    rows_eff = (rows_done_q >= h) ? '0 : rows_done_q;
    row_full = bottom_up_q ? (h - DimW'(1) - rows_eff) : rows_eff;
    col_next = {2'b00, col_count_q} + (DimW+1)'(1);
    rows_next = {1'b0, rows_eff} + (DimW+1)'(1);
    last_col = col_next >= {1'b0, w};
    last_row = rows_next >= {1'b0, h};
    pad_prod = 2'(bpp[1:0] * w[1:0]);

    alpha_d = '0;
    if (pixel_format_q == FmtRgb555) begin
      blue_d  = 8'(v555 & MaskBlue555);
      green_d = 8'((v555 & MaskGreen555) >> 5);
      red_d   = 8'((v555 & MaskRed555) >> 10);
    end else begin
      blue_d  = pixel_bytes_q[7:0];
      green_d = pixel_bytes_q[15:8];
      if (pixel_format_q == FmtBgra32) begin
        red_d   = pixel_bytes_q[23:16];
        alpha_d = s1_byte_q;
      end else begin
        red_d = s1_byte_q;
      end
    end

    if (s1_fire) begin
      if (pad_left_q != '0) begin
        pad_left_d = pad_left_q - 2'd1;
      end else if (({1'b0, byte_phase_q} + 3'd1) < bpp) begin
        pixel_bytes_d = pixel_bytes_q | (24'(s1_byte_q) << {byte_phase_q, 3'b000});
        byte_phase_d  = byte_phase_q + 2'd1;
      end else begin
        emit          = 1'b1;
        byte_phase_d  = '0;
        pixel_bytes_d = '0;
        rows_done_d   = rows_eff;
        if (last_col) begin
          col_count_d = '0;
          pad_left_d  = 2'd0 - pad_prod;
          rows_done_d = last_row ? '0 : rows_next[DimW-1:0];
        end else begin
          col_count_d = col_next[CoordW-1:0];
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_format_q <= FmtBgr24;
      image_width_q  <= DimW'(1);
      image_height_q <= DimW'(1);
      bottom_up_q    <= 1'b1;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      byte_phase_q   <= '0;
      pixel_bytes_q  <= '0;
      col_count_q    <= '0;
      rows_done_q    <= '0;
      pad_left_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgPixelFormat: pixel_format_q <= cfg_data_i[1:0];
          CfgImageWidth:  image_width_q  <= cfg_data_i;
          CfgImageHeight: image_height_q <= cfg_data_i;
          CfgBottomUp:    bottom_up_q    <= cfg_data_i[0];
          default:        ;
        endcase
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      byte_phase_q  <= byte_phase_d;
      pixel_bytes_q <= pixel_bytes_d;
      col_count_q   <= col_count_d;
      rows_done_q   <= rows_done_d;
      pad_left_q    <= pad_left_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= data_byte_i;
    end
    if (emit) begin
      red_q        <= red_d;
      green_q      <= green_d;
      blue_q       <= blue_d;
      alpha_q      <= alpha_d;
      column_q     <= col_count_q;
      row_q        <= row_full[CoordW-1:0];
      frame_last_q <= last_col && last_row;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_o        = red_q;
  assign green_o      = green_q;
  assign blue_o       = blue_q;
  assign alpha_o      = alpha_q;
  assign column_o     = column_q;
  assign row_o        = row_q;
  assign frame_last_o = frame_last_q;

  // padding is only skipped between pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pad_left_q != 2'd0) |-> (byte_phase_q == 2'd0))
    else $error("padding pending in the middle of a pixel");

  // an empty output register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty output register");

  // a frame end restarts the row count and column count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_col && last_row) |=> (rows_done_q == '0 && col_count_q == '0))
    else $error("counters not cleared at frame end");

  // a pixel is never loaded over one that is not being taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");

endmodule

>>> tb/bmp_pixel_row_unpacker_test.sv
`timescale 1ns / 1ps

module bmp_pixel_row_unpacker_test;
  import bpru_pkg::*;

  localparam int unsigned MaxWidth    = 4096;
  localparam int unsigned MaxHeight   = 4096;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned RandomBytes = 2000;
  localparam int unsigned SettleCycles = 4;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [11:0] column;
    logic [11:0] row;
    logic        frame_last;
  } pixel_t;

  // pixel predictor and queue of pixels still owed by the block
  class pixel_scoreboard;
    logic [1:0]  pix_fmt;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic        flip_rows;
    int unsigned beat;
    logic [23:0] gathered;
    int unsigned col;
    int unsigned rows_seen;
    int unsigned pad_skip;
    pixel_t      pending_pixels[$];
    int unsigned errors;

    function new();
      pix_fmt    = FmtBgr24;
      width_reg  = 13'd1;
      height_reg = 13'd1;
      flip_rows  = 1'b1;
      beat       = 0;
      gathered   = '0;
      col        = 0;
      rows_seen  = 0;
      pad_skip   = 0;
      errors     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [12:0] val);
      case (idx)
        CfgPixelFormat: pix_fmt = val[1:0];
        CfgImageWidth:  width_reg = val;
        CfgImageHeight: height_reg = val;
        CfgBottomUp:    flip_rows = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    // one accepted byte: padding skip, byte gathering or a finished pixel
    function void note_byte(logic [7:0] b);
      int unsigned bpp;
      int unsigned w;
      int unsigned h;
      logic [15:0] word;
      pixel_t      px;
      logic        last_col;
      logic        last_row;
      if (pad_skip != 0) begin
        pad_skip--;
        return;
      end
      case (pix_fmt)
        FmtRgb555: bpp = BppRgb555;
        FmtBgra32: bpp = BppBgra32;
        default:   bpp = BppBgr24;
      endcase
      if (beat + 1 < bpp) begin
        gathered = gathered | (24'(b) << (8 * beat));
        beat++;
        return;
      end
      w = clamp_dim(width_reg, MaxWidth);
      h = clamp_dim(height_reg, MaxHeight);

      // color unpacking
      px.alpha = 8'd0;
      if (pix_fmt == FmtRgb555) begin
        word     = {b, gathered[7:0]};
        px.blue  = 8'(word & MaskBlue555);
        px.green = 8'((word & MaskGreen555) >> 5);
        px.red   = 8'((word & MaskRed555) >> 10);
      end else begin
        px.blue  = gathered[7:0];
        px.green = gathered[15:8];
        if (pix_fmt == FmtBgra32) begin
          px.red   = gathered[23:16];
          px.alpha = b;
        end else begin
          px.red = b;
        end
      end

      // coordinates
      if (rows_seen >= h) rows_seen = 0;
      px.row        = flip_rows ? 12'(h - 1 - rows_seen) : 12'(rows_seen);
      px.column     = 12'(col);
      last_col      = (col + 1 >= w);
      last_row      = (rows_seen + 1 >= h);
      px.frame_last = last_col && last_row;
      pending_pixels.push_back(px);

      // advance to the next pixel, row or frame
      beat     = 0;
      gathered = '0;
      if (last_col) begin
        col       = 0;
        pad_skip  = (4 - (bpp * w) % 4) % 4;
        rows_seen = last_row ? 0 : ((rows_seen + 1) & 32'h1FFF);
      end else begin
        col = (col + 1) & 32'hFFF;
      end
    endfunction

    function string describe(pixel_t p);
      return $sformatf("r=%02h g=%02h b=%02h a=%02h col=%0d row=%0d last=%0b",
                       p.red, p.green, p.blue, p.alpha, p.column, p.row, p.frame_last);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= ReportLimit) $display("%0t: %s", $time, msg);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("pixel with none expected: %s", describe(got)));
        return;
      end
      want = pending_pixels.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.alpha !== want.alpha || got.column !== want.column ||
          got.row !== want.row || got.frame_last !== want.frame_last)
        report($sformatf("pixel mismatch: expected %s, actual %s",
                         describe(want), describe(got)));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [12:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [7:0]  alpha_o;
  logic [11:0] column_o;
  logic [11:0] row_o;
  logic        frame_last_o;

  pixel_scoreboard sb;
  int unsigned     src_idle_pct;
  int unsigned     sink_idle_pct;

  bmp_pixel_row_unpacker dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_o      (alpha_o),
    .column_o     (column_o),
    .row_o        (row_o),
    .frame_last_o (frame_last_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
  end

  // pixel monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_pixel(pixel_t'{red_o, green_o, blue_o, alpha_o, column_o, row_o,
                              frame_last_o});
  end

  // one byte transaction; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_byte(b);
    @(negedge clk_i);
  endtask

  task automatic send_seq(input logic [7:0] seq[$]);
    foreach (seq[k]) send_byte(seq[k]);
  endtask

  // wait until every owed pixel is out and the input stage is empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // all four registers, valid held high across the writes
  task automatic configure(input logic [12:0] fmt_v, input logic [12:0] w_v,
                           input logic [12:0] h_v, input logic [12:0] bu_v);
    logic [1:0]  idx[4];
    logic [12:0] val[4];
    idx = '{CfgPixelFormat, CfgImageWidth, CfgImageHeight, CfgBottomUp};
    val = '{fmt_v, w_v, h_v, bu_v};
    for (int k = 0; k < 4; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      sb.write_reg(idx[k], val[k]);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // random setting followed by whole frames, or a cut-off stream now and then
  task automatic random_phase(input int unsigned budget, output int unsigned sent);
    logic [1:0]  fmt_code;
    logic [12:0] fmt_v;
    logic [12:0] w_v;
    logic [12:0] h_v;
    logic [12:0] bu_v;
    int unsigned bpp;
    int unsigned w;
    int unsigned h;
    int unsigned frame_bytes;
    int unsigned pick;
    pick = $urandom_range(9);
    fmt_code = (pick < 3) ? FmtRgb555 : (pick < 6) ? FmtBgr24 :
               (pick < 9) ? FmtBgra32 : 2'd3;
    fmt_v = {11'd0, fmt_code};
    bu_v  = 13'($urandom_range(1));
    if ($urandom_range(3) == 0) begin
      fmt_v[12:2] = 11'($urandom);
      bu_v[12:1]  = 12'($urandom);
    end

    pick = $urandom_range(19);
    if (pick == 0)      w_v = 13'd0;
    else if (pick == 1) w_v = 13'($urandom_range(4096, 8191));
    else if (pick < 4)  w_v = 13'($urandom_range(9, 64));
    else                w_v = 13'($urandom_range(1, 8));
    pick = $urandom_range(19);
    if (pick == 0)      h_v = 13'd0;
    else if (pick == 1) h_v = 13'($urandom_range(4000, 8191));
    else                h_v = 13'($urandom_range(1, 5));
    configure(fmt_v, w_v, h_v, bu_v);

    bpp = (fmt_code == FmtRgb555) ? BppRgb555 : (fmt_code == FmtBgra32) ? BppBgra32 :
          BppBgr24;
    w = (w_v == 0) ? 1 : (w_v > MaxWidth) ? MaxWidth : w_v;
    h = (h_v == 0) ? 1 : (h_v > MaxHeight) ? MaxHeight : h_v;
    frame_bytes = h * (w * bpp + (4 - (w * bpp) % 4) % 4);
    if (frame_bytes <= 1200 && $urandom_range(5) != 0)
      sent = frame_bytes * $urandom_range(1, 2);
    else
      sent = $urandom_range(1, (frame_bytes < 300) ? frame_bytes : 300);
    if (sent > budget) sent = budget;
    repeat (sent) send_byte(8'($urandom_range(255)));
    settle();
  endtask

  // stimulus
  initial begin
    int unsigned rand_bytes;
    int unsigned sent;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CfgPixelFormat;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    data_byte_i   = '0;
    out_ready_i   = 1'b0;
    src_idle_pct  = 27;
    sink_idle_pct = 55;
    rand_bytes    = 0;
    sb = new();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset setting: 24-bit 1x1, one padding byte after every pixel
    send_seq({8'h00, 8'h00, 8'h00, 8'hA5, 8'hFF, 8'hFF, 8'hFF, 8'h5A});
    settle();
    // 5:5:5 2x2 top-down: all ones, top bit alone, blue alone, red and green
    configure({11'd0, FmtRgb555}, 13'd2, 13'd2, 13'd0);
    send_seq({8'hFF, 8'hFF, 8'h00, 8'h80, 8'h1F, 8'h00, 8'hE0, 8'h7F});
    settle();
    // 32-bit with full alpha
    configure({11'd0, FmtBgra32}, 13'd1, 13'd1, 13'd1);
    send_seq({8'h11, 8'h22, 8'h33, 8'hFF});
    settle();
    // unused format code with zero width and height
    configure(13'd3, 13'd0, 13'd0, 13'd0);
    send_seq({8'hC3, 8'h3C, 8'h96, 8'h69});
    settle();

    // random settings and streams, idling swapped after a third, then none
    while (rand_bytes < RandomBytes) begin
      if (rand_bytes < RandomBytes / 3) begin
        src_idle_pct  = 27;
        sink_idle_pct = 55;
      end else if (rand_bytes < 2 * RandomBytes / 3) begin
        src_idle_pct  = 55;
        sink_idle_pct = 27;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      random_phase(RandomBytes - rand_bytes, sent);
      rand_bytes += sent;
    end

    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
